// ===== src/e2g_pkg.sv =====
// shared types, constants and fixed-point helpers for the geocentric to geodetic converter
package e2g_pkg;

  typedef logic signed [63:0] q_t;

  localparam int QF = 46;
  localparam q_t ONE_Q = 64'sh0000_4000_0000_0000;
  localparam q_t TWO_Q = 64'sh0000_8000_0000_0000;
  localparam q_t SATV  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOL_RAW = 64'd70;
  localparam logic [63:0] NORM_HI = 64'h1000_0000_0000_0000;
  localparam logic [63:0] NORM_LO = 64'h0400_0000_0000_0000;

  localparam logic [1:0] REG_SEMI_MAJOR = 2'd0;
  localparam logic [1:0] REG_SEMI_MINOR = 2'd1;
  localparam logic [1:0] REG_ECC_SQ     = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SINGULAR = 2'd1;
  localparam logic [1:0] STAT_ZERO_SUM = 2'd2;

  localparam logic [31:0] ANG_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] ANG_QTR  = 32'h4000_0000;
  localparam logic [31:0] ANG_HALF = 32'h8000_0000;
  localparam logic signed [39:0] H_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] H_MIN = 40'sh80_0000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MXX, ST_MYY, ST_MZZ, ST_SQP, ST_SQR, ST_LON, ST_DST, ST_DCT,
    ST_ST2, ST_K1, ST_K2, ST_IS1, ST_IS2, ST_C1, ST_C2, ST_C3, ST_D1, ST_D2,
    ST_W1, ST_W2, ST_W3, ST_W4, ST_H1, ST_H2, ST_H3, ST_RK1, ST_RK2, ST_LAT
  } seq_state_e;

  typedef enum logic [1:0] {
    COR_IDLE, COR_NORM, COR_ROT
  } cor_state_e;

  function automatic logic [63:0] q_mag(input q_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic q_t q_sadd(input q_t a, input q_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SATV)) return SATV;
    if (s < -65'(SATV)) return -SATV;
    return s[63:0];
  endfunction

  function automatic q_t q_ssub(input q_t a, input q_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(SATV)) return SATV;
    if (s < -65'(SATV)) return -SATV;
    return s[63:0];
  endfunction

  // rescale a 128-bit magnitude product back to q46 with saturation
  function automatic q_t q_fix(input logic [127:0] w, input logic neg);
    logic [63:0] v;
    v = w[109:46];
    if ((|w[127:110]) || v[63]) v = 64'(SATV);
    return neg ? -q_t'(v) : q_t'(v);
  endfunction

  function automatic logic signed [39:0] sat40(input q_t v);
    if (v > 64'(H_MAX)) return H_MAX;
    if (v < 64'(H_MIN)) return H_MIN;
    return v[39:0];
  endfunction

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E; 5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4; 5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55; 5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001; default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== src/e2g_mul.sv =====
// 64x64 unsigned multiplier built from one 32x32 multiplier that forms the four partial products in turn
module e2g_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);
  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q, acc_d;
  logic [1:0]   k_q;
  logic         run_q, done_q;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    ah = k_q[1] ? a_q[63:32] : a_q[31:0];
    bh = k_q[0] ? b_q[63:32] : b_q[31:0];
    pp = 64'(ah) * 64'(bh);
    unique case (k_q)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
    acc_d = acc_q + pp_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        k_q   <= 2'd0;
      end else if (run_q) begin
        k_q <= k_q + 2'd1;
        if (k_q == 2'd3) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ===== src/e2g_div.sv =====
// radix-2 restoring divider, 128-bit dividend by 64-bit divisor, saturating quotient
module e2g_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] n_i,
  input  logic [63:0]  d_i,
  output logic         done_o,
  output logic [63:0]  q_o
);
  import e2g_pkg::*;

  logic [127:0] nq_q;
  logic [63:0]  r_q, d_q, r_d;
  logic [64:0]  r_sh, r_sub;
  logic         bad_q, ge;
  logic [6:0]   cnt_q;
  logic         run_q, done_q;

  always_comb begin
    r_sh  = {r_q, nq_q[127]};
    r_sub = r_sh - {1'b0, d_q};
    ge    = r_sh >= {1'b0, d_q};
    r_d   = ge ? r_sub[63:0] : r_sh[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= n_i;
      r_q   <= '0;
      d_q   <= d_i;
      bad_q <= (d_i == 64'd0) || d_i[63];
    end else if (run_q) begin
      nq_q <= {nq_q[126:0], ge};
      r_q  <= r_d;
    end
  end

  // quotient above the q46 range saturates, as does a zero divisor or one with bit 63 set
  assign q_o    = (bad_q || (|nq_q[127:63])) ? 64'(SATV) : nq_q[63:0];
  assign done_o = done_q;
endmodule

// ===== src/e2g_sqrt.sv =====
// digit-by-digit integer square root of a 128-bit value, one result bit per cycle
module e2g_sqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] n_i,
  output logic         done_o,
  output logic [63:0]  root_o
);
  logic [127:0] n_q;
  logic [64:0]  rem_q;
  logic [63:0]  root_q;
  logic [66:0]  rem_sh, trial, rem_sub;
  logic         ge;
  logic [5:0]   cnt_q;
  logic         run_q, done_q;

  always_comb begin
    rem_sh  = {rem_q, n_q[127:126]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      n_q    <= {n_q[125:0], 2'b00};
      rem_q  <= ge ? rem_sub[64:0] : rem_sh[64:0];
      root_q <= {root_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== src/e2g_cordic.sv =====
// vectoring cordic giving atan2 as a binary angle, normalise then 32 rotations
module e2g_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  e2g_pkg::q_t       x_i,
  input  e2g_pkg::q_t       y_i,
  output logic              done_o,
  output logic [31:0]       angle_o
);
  import e2g_pkg::*;

  cor_state_e state_q, state_d;
  q_t          x_q, y_q, x_d, y_d, dx, dy;
  logic [31:0] z_q, z_d;
  logic [4:0]  i_q, i_d;
  logic        done_d, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COR_IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    done_d  = 1'b0;
    dx      = x_q >>> i_q;
    dy      = y_q >>> i_q;
    unique case (state_q)
      COR_IDLE: begin
        if (start_i) begin
          x_d     = x_i;
          y_d     = y_i;
          z_d     = '0;
          state_d = COR_NORM;
        end
      end
      COR_NORM: begin
        priority if (x_q == '0 && y_q == '0) begin
          done_d  = 1'b1;
          state_d = COR_IDLE;
        end else if (q_mag(x_q) >= NORM_HI || q_mag(y_q) >= NORM_HI) begin
          x_d = x_q >>> 1;
          y_d = y_q >>> 1;
        end else if (q_mag(x_q) < NORM_LO && q_mag(y_q) < NORM_LO) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else begin
          // fold the left half plane onto the right one
          if (x_q[63]) begin
            x_d = -x_q;
            y_d = -y_q;
            z_d = ANG_HALF;
          end
          i_d     = '0;
          state_d = COR_ROT;
        end
      end
      COR_ROT: begin
        if (!y_q[63] && y_q != '0) begin
          x_d = x_q + dy;
          y_d = y_q - dx;
          z_d = z_q + atan_lut(i_q);
        end else if (y_q[63]) begin
          x_d = x_q - dy;
          y_d = y_q + dx;
          z_d = z_q - atan_lut(i_q);
        end
        i_d = i_q + 5'd1;
        if (i_q == 5'd31) begin
          done_d  = 1'b1;
          state_d = COR_IDLE;
        end
      end
      default: state_d = COR_IDLE;
    endcase
  end

  assign done_o  = done_q;
  assign angle_o = z_q;
endmodule

// ===== src/ecef_to_geodetic_iterative_top.sv =====
// geocentric x/y/z to geodetic latitude, longitude and height, one shared unit set under a sequencer
//
// usage: write the ellipsoid registers through cfg_we_i/cfg_idx_i/cfg_wdata_i while the block
// is idle (index 0 semi-major axis, 1 semi-minor axis, 2 eccentricity squared; index 3 ignored).
// a transaction is taken when start is high and busy is low; pos_*_i are sampled then.
// busy stays high until the result goes out; result_valid_o is high for exactly one cycle
// with latitude, longitude, height, status and pass count, and busy drops in that same cycle,
// so start may be raised again at once. the receiver cannot hold a result off.
// work: outside the passes three squares, three roots, three divides, six multiplies and two
// atan2; each refinement pass is three divides, two roots and thirteen multiplies, at most
// MAX_ITER passes. the centre point finishes after the two roots, a singular denominator or
// zero radius sum ends the point early.
// one transaction at a time: a new point is taken only once the previous result has gone out.
// reset returns the sequencer to idle and loads the wgs84 ellipsoid into the registers.
module ecef_to_geodetic_iterative_top #(
  parameter int MAX_ITER = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [39:0]         cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  logic signed [39:0]  pos_x_i,
  input  logic signed [39:0]  pos_y_i,
  input  logic signed [39:0]  pos_z_i,
  output logic                result_valid_o,
  output logic signed [31:0]  lat_angle_o,
  output logic signed [31:0]  lon_angle_o,
  output logic signed [39:0]  height_out_o,
  output logic [1:0]          status_o,
  output logic [4:0]          iterations_used_o
);
  import e2g_pkg::*;

  localparam int IW = $clog2(MAX_ITER + 1);

  // configuration registers
  logic [30:0] semi_major_q, semi_minor_q;
  logic [39:0] ecc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semi_major_q <= 31'd1632803072;
      semi_minor_q <= 31'd1627328592;
      ecc_q        <= 40'd7360548660;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEMI_MAJOR: semi_major_q <= cfg_wdata_i[30:0];
        REG_SEMI_MINOR: semi_minor_q <= cfg_wdata_i[30:0];
        REG_ECC_SQ:     ecc_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  q_t e2q;
  assign e2q = q_t'({18'b0, ecc_q, 6'b0});

  // shared units
  logic         mul_go, mul_done;
  logic [127:0] mul_p;
  q_t           qa, qb, prod;
  logic         div_go, div_done;
  logic [127:0] div_n;
  logic [63:0]  div_d, div_q;
  logic         sq_go, sq_done;
  logic [127:0] sq_n;
  logic [63:0]  sq_root;
  logic         cor_go, cor_done;
  q_t           cor_x, cor_y;
  logic [31:0]  cor_ang;

  e2g_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_go), .a_i(q_mag(qa)), .b_i(q_mag(qb)),
    .done_o(mul_done), .p_o(mul_p)
  );
  e2g_div u_div (
    .clk_i, .rst_ni, .start_i(div_go), .n_i(div_n), .d_i(div_d),
    .done_o(div_done), .q_o(div_q)
  );
  e2g_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_go), .n_i(sq_n), .done_o(sq_done), .root_o(sq_root)
  );
  e2g_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_go), .x_i(cor_x), .y_i(cor_y),
    .done_o(cor_done), .angle_o(cor_ang)
  );

  assign prod = q_fix(mul_p, qa[63] ^ qb[63]);

  // sequencer state
  seq_state_e  state_q, state_d;
  logic        wait_q, wait_d, first_q, first_d;
  logic [IW-1:0] it_q, it_d;
  q_t          x_q, y_q, z_q, x_d, y_d, z_d;
  logic [127:0] s2_q, s2_d, acc_q, acc_d;
  logic [63:0] p_q, p_d, rr_q, rr_d, sq_q, sq_d;
  q_t st_q, st_d, ct_q, ct_d, st2_q, st2_d, k_q, k_d, t_q, t_d, den_q, den_d;
  q_t rx_q, rx_d, c_q, c_d, s_q, s_d, c0_q, c0_d, s0_q, s0_d;
  q_t w_q, w_d, rn_q, rn_d, h_q, h_d, rnh_q, rnh_d;
  q_t den_c, w_c, sd_c, h_c, rnh_c;
  logic [31:0] lon_q, lon_d;

  logic              emit;
  logic [31:0]       e_lat, e_lon;
  q_t                e_h;
  logic [1:0]        e_st;
  logic [IW-1:0]     e_it;
  logic              valid_q;
  logic [31:0]       lat_out_q, lon_out_q;
  logic signed [39:0] h_out_q;
  logic [1:0]        st_out_q;
  logic [4:0]        it_out_q;
  logic [6:0]        e_it_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
      first_q <= 1'b0;
      it_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      first_q <= first_d;
      it_q    <= it_d;
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;  y_q <= y_d;  z_q <= z_d;
    s2_q <= s2_d;  acc_q <= acc_d;  p_q <= p_d;  rr_q <= rr_d;  sq_q <= sq_d;
    st_q <= st_d;  ct_q <= ct_d;  st2_q <= st2_d;  k_q <= k_d;  t_q <= t_d;
    den_q <= den_d;  rx_q <= rx_d;  c_q <= c_d;  s_q <= s_d;
    c0_q <= c0_d;  s0_q <= s0_d;  w_q <= w_d;  rn_q <= rn_d;
    h_q <= h_d;  rnh_q <= rnh_d;  lon_q <= lon_d;
    if (emit) begin
      lat_out_q <= e_lat;
      lon_out_q <= e_lon;
      h_out_q   <= sat40(e_h);
      st_out_q  <= e_st;
      it_out_q  <= (e_it_ext > 7'd31) ? 5'd31 : e_it_ext[4:0];
    end
  end

  assign e_it_ext = 7'(e_it);

  always_comb begin
    state_d = state_q;  wait_d = wait_q;  first_d = first_q;  it_d = it_q;
    x_d = x_q;  y_d = y_q;  z_d = z_q;
    s2_d = s2_q;  acc_d = acc_q;  p_d = p_q;  rr_d = rr_q;  sq_d = sq_q;
    st_d = st_q;  ct_d = ct_q;  st2_d = st2_q;  k_d = k_q;  t_d = t_q;
    den_d = den_q;  rx_d = rx_q;  c_d = c_q;  s_d = s_q;
    c0_d = c0_q;  s0_d = s0_q;  w_d = w_q;  rn_d = rn_q;
    h_d = h_q;  rnh_d = rnh_q;  lon_d = lon_q;
    mul_go = 1'b0;  div_go = 1'b0;  sq_go = 1'b0;  cor_go = 1'b0;
    qa = x_q;  qb = x_q;
    div_n = acc_q;  div_d = sq_q;  sq_n = s2_q;
    cor_x = x_q;  cor_y = y_q;
    emit = 1'b0;  e_lat = '0;  e_lon = lon_q;  e_h = h_q;  e_st = STAT_OK;  e_it = it_q;
    den_c = q_ssub(ONE_Q, prod);
    w_c   = q_ssub(ONE_Q, prod);
    if (w_c[63] || w_c == '0) w_c = q_t'(1);
    sd_c  = q_ssub(t_q, prod);
    h_c   = q_ssub(t_q, prod);
    rnh_c = q_sadd(rn_q, h_c);

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          x_d = 64'(pos_x_i);
          y_d = 64'(pos_y_i);
          z_d = 64'(pos_z_i);
          k_d = e2q;
          lon_d = '0;
          it_d = '0;
          first_d = 1'b1;
          wait_d = 1'b0;
          state_d = ST_MXX;
        end
      end
      ST_MXX: begin
        qa = x_q;  qb = x_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin acc_d = mul_p; wait_d = 1'b0; state_d = ST_MYY; end
      end
      ST_MYY: begin
        qa = y_q;  qb = y_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin s2_d = acc_q + mul_p; wait_d = 1'b0; state_d = ST_MZZ; end
      end
      ST_MZZ: begin
        qa = z_q;  qb = z_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin acc_d = s2_q + mul_p; wait_d = 1'b0; state_d = ST_SQP; end
      end
      ST_SQP: begin
        sq_n = s2_q;
        if (!wait_q) begin sq_go = 1'b1; wait_d = 1'b1; end
        else if (sq_done) begin p_d = sq_root; wait_d = 1'b0; state_d = ST_SQR; end
      end
      ST_SQR: begin
        sq_n = acc_q;
        if (!wait_q) begin sq_go = 1'b1; wait_d = 1'b1; end
        else if (sq_done) begin
          rr_d = sq_root;
          wait_d = 1'b0;
          if (x_q == '0 && y_q == '0) begin
            // centre point goes straight out, polar axis keeps longitude zero
            if (z_q == '0) begin
              emit = 1'b1;  e_lat = ANG_QTR;  e_lon = '0;
              e_h = -q_t'({33'b0, semi_minor_q});  e_st = STAT_OK;  e_it = '0;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_DST;
            end
          end else begin
            state_d = ST_LON;
          end
        end
      end
      ST_LON: begin
        cor_x = x_q;  cor_y = y_q;
        if (!wait_q) begin cor_go = 1'b1; wait_d = 1'b1; end
        else if (cor_done) begin lon_d = cor_ang; wait_d = 1'b0; state_d = ST_DST; end
      end
      ST_DST: begin
        div_n = 128'(p_q) << QF;  div_d = rr_q;
        if (!wait_q) begin div_go = 1'b1; wait_d = 1'b1; end
        else if (div_done) begin st_d = q_t'(div_q); wait_d = 1'b0; state_d = ST_DCT; end
      end
      ST_DCT: begin
        div_n = 128'(q_mag(z_q)) << QF;  div_d = rr_q;
        if (!wait_q) begin div_go = 1'b1; wait_d = 1'b1; end
        else if (div_done) begin
          ct_d = z_q[63] ? -q_t'(div_q) : q_t'(div_q);
          wait_d = 1'b0;
          state_d = ST_ST2;
        end
      end
      ST_ST2: begin
        qa = st_q;  qb = st_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin st2_d = prod; wait_d = 1'b0; state_d = ST_K1; end
      end
      ST_K1: begin
        qa = k_q;  qb = q_ssub(TWO_Q, k_q);
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin t_d = prod; wait_d = 1'b0; state_d = ST_K2; end
      end
      ST_K2: begin
        qa = t_q;  qb = st2_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin
          den_d = den_c;
          wait_d = 1'b0;
          if (den_c[63] || den_c == '0) begin
            emit = 1'b1;  e_lat = ANG_MAX;  e_lon = ANG_MAX;
            e_h = 64'(H_MAX);  e_st = STAT_SINGULAR;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_IS1;
          end
        end
      end
      ST_IS1: begin
        sq_n = 128'(den_q) << QF;
        if (!wait_q) begin sq_go = 1'b1; wait_d = 1'b1; end
        else if (sq_done) begin sq_d = sq_root; wait_d = 1'b0; state_d = ST_IS2; end
      end
      ST_IS2: begin
        div_n = 128'(1) << (2 * QF);  div_d = sq_q;
        if (!wait_q) begin div_go = 1'b1; wait_d = 1'b1; end
        else if (div_done) begin rx_d = q_t'(div_q); wait_d = 1'b0; state_d = ST_C1; end
      end
      ST_C1: begin
        qa = st_q;  qb = q_ssub(ONE_Q, k_q);
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin t_d = prod; wait_d = 1'b0; state_d = ST_C2; end
      end
      ST_C2: begin
        qa = t_q;  qb = rx_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin c_d = prod; wait_d = 1'b0; state_d = ST_C3; end
      end
      ST_C3: begin
        qa = ct_q;  qb = rx_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin
          s_d = prod;
          wait_d = 1'b0;
          if (first_q) begin
            // start values for the first refinement pass
            c0_d = c_q;
            s0_d = prod;
            first_d = 1'b0;
            state_d = ST_W1;
          end else begin
            state_d = ST_D1;
          end
        end
      end
      ST_D1: begin
        qa = s_q;  qb = c0_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin t_d = prod; wait_d = 1'b0; state_d = ST_D2; end
      end
      ST_D2: begin
        qa = c_q;  qb = s0_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin
          c0_d = c_q;
          s0_d = s_q;
          wait_d = 1'b0;
          if (q_mag(sd_c) > TOL_RAW && it_q < IW'(MAX_ITER)) state_d = ST_W1;
          else state_d = ST_LAT;
        end
      end
      ST_W1: begin
        qa = s0_q;  qb = s0_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; it_d = it_q + IW'(1); end
        else if (mul_done) begin t_d = prod; wait_d = 1'b0; state_d = ST_W2; end
      end
      ST_W2: begin
        qa = e2q;  qb = t_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin w_d = w_c; wait_d = 1'b0; state_d = ST_W3; end
      end
      ST_W3: begin
        sq_n = 128'(w_q) << QF;
        if (!wait_q) begin sq_go = 1'b1; wait_d = 1'b1; end
        else if (sq_done) begin sq_d = sq_root; wait_d = 1'b0; state_d = ST_W4; end
      end
      ST_W4: begin
        div_n = 128'(semi_major_q) << QF;  div_d = sq_q;
        if (!wait_q) begin div_go = 1'b1; wait_d = 1'b1; end
        else if (div_done) begin rn_d = q_t'(div_q); wait_d = 1'b0; state_d = ST_H1; end
      end
      ST_H1: begin
        qa = q_t'(p_q);  qb = c0_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin t_d = prod; wait_d = 1'b0; state_d = ST_H2; end
      end
      ST_H2: begin
        qa = z_q;  qb = s0_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin t_d = q_sadd(t_q, prod); wait_d = 1'b0; state_d = ST_H3; end
      end
      ST_H3: begin
        qa = rn_q;  qb = w_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin
          h_d = h_c;
          rnh_d = rnh_c;
          wait_d = 1'b0;
          if (rnh_c == '0) begin
            emit = 1'b1;  e_lat = '0;  e_lon = lon_q;  e_h = h_c;  e_st = STAT_ZERO_SUM;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RK1;
          end
        end
      end
      ST_RK1: begin
        qa = e2q;  qb = rn_q;
        if (!wait_q) begin mul_go = 1'b1; wait_d = 1'b1; end
        else if (mul_done) begin acc_d = mul_p; wait_d = 1'b0; state_d = ST_RK2; end
      end
      ST_RK2: begin
        div_n = acc_q;  div_d = q_mag(rnh_q);
        if (!wait_q) begin div_go = 1'b1; wait_d = 1'b1; end
        else if (div_done) begin
          k_d = rnh_q[63] ? -q_t'(div_q) : q_t'(div_q);
          wait_d = 1'b0;
          state_d = ST_K1;
        end
      end
      ST_LAT: begin
        cor_x = q_t'(q_mag(c0_q));  cor_y = s0_q;
        if (!wait_q) begin cor_go = 1'b1; wait_d = 1'b1; end
        else if (cor_done) begin
          wait_d = 1'b0;
          emit = 1'b1;  e_lat = cor_ang;  e_lon = lon_q;  e_h = h_q;  e_st = STAT_OK;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy              = (state_q != ST_IDLE);
  assign result_valid_o    = valid_q;
  assign lat_angle_o       = lat_out_q;
  assign lon_angle_o       = lon_out_q;
  assign height_out_o      = h_out_q;
  assign status_o          = st_out_q;
  assign iterations_used_o = it_out_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe without a transaction in flight");

  a_singular_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == STAT_SINGULAR) |->
      (lat_angle_o == ANG_MAX && lon_angle_o == ANG_MAX && height_out_o == H_MAX))
    else $error("singular result not saturated");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ({2'b00, iterations_used_o} <= 7'(MAX_ITER)))
    else $error("pass count above limit");

endmodule
